// ===== sv/trpm_pkg.sv =====
`timescale 1ns / 1ps

package trpm_pkg;

  // Field and register widths fixed by the interface.
  localparam int TS_W       = 32;
  localparam int MIN_GAP_W  = 20;
  localparam int MAX_PER_W  = 24;
  localparam int HOLD_W     = 8;
  localparam int RPM_W      = 26;
  localparam int ACC_W      = 34;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Divider geometry: constant numerator over a divisor of MAX_PER_W bits.
  localparam int DIV_W     = MAX_PER_W;
  localparam int NUM_W     = RPM_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [NUM_W-1:0] RPM_NUMERATOR = NUM_W'(60000000);

  // Register reset values.
  localparam logic [MIN_GAP_W-1:0] MIN_GAP_RST = MIN_GAP_W'(2000);
  localparam logic [MAX_PER_W-1:0] MAX_PER_RST = MAX_PER_W'(1000000);
  localparam logic [HOLD_W-1:0]    HOLD_RST    = HOLD_W'(20);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 2'd2;

  // Item operation codes.
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [MIN_GAP_W-1:0] min_gap_us;
    logic [MAX_PER_W-1:0] max_period_us;
    logic [HOLD_W-1:0]    hold_ticks;
  } trpm_cfg_t;

  typedef struct packed {
    logic            op;
    logic [TS_W-1:0] timestamp_us;
    logic            pin_level;
  } trpm_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CHECK,
    ST_DIVIDE,
    ST_DONE
  } trpm_state_t;

endpackage

// ===== sv/trpm_regs.sv =====
`timescale 1ns / 1ps

module trpm_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [trpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trpm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output trpm_pkg::trpm_cfg_t              cfg
);

  trpm_pkg::trpm_cfg_t cfg_r;
  trpm_pkg::trpm_cfg_t cfg_nxt;

  // Writes are to arrive only while the block is idle; the block does not enforce it. The port is always open.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode the register index; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        trpm_pkg::REG_MIN_GAP:
          cfg_nxt.min_gap_us = cfg_data[trpm_pkg::MIN_GAP_W-1:0];
        trpm_pkg::REG_MAX_PERIOD:
          cfg_nxt.max_period_us = cfg_data[trpm_pkg::MAX_PER_W-1:0];
        trpm_pkg::REG_HOLD_TICKS:
          cfg_nxt.hold_ticks = cfg_data[trpm_pkg::HOLD_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_gap_us    <= trpm_pkg::MIN_GAP_RST;
      cfg_r.max_period_us <= trpm_pkg::MAX_PER_RST;
      cfg_r.hold_ticks    <= trpm_pkg::HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== sv/trpm_state.sv =====
`timescale 1ns / 1ps

module trpm_state #(
  parameter int FILTER_SHIFT = 2,
  parameter int TIME_WIDTH   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            apply,
  input  trpm_pkg::trpm_item_t            item,
  input  trpm_pkg::trpm_cfg_t             cfg,
  output logic [trpm_pkg::ACC_W-1:0]      acc,
  output logic                            hold_nz
);

  localparam int PERIOD_W = (TIME_WIDTH < trpm_pkg::TS_W) ? TIME_WIDTH : trpm_pkg::TS_W;
  localparam int CMP_W    = (TIME_WIDTH > trpm_pkg::MIN_GAP_W) ? TIME_WIDTH
                                                              : trpm_pkg::MIN_GAP_W;
  localparam int ACC_W    = trpm_pkg::ACC_W;

  logic [ACC_W-1:0]               acc_r, acc_nxt;
  logic [PERIOD_W-1:0]            period_r, period_nxt;
  logic [trpm_pkg::HOLD_W-1:0]    hold_r, hold_nxt;
  logic [TIME_WIDTH-1:0]          prev_edge_r, prev_edge_nxt;
  logic [TIME_WIDTH-1:0]          prev_valid_r, prev_valid_nxt;

  logic [TIME_WIDTH-1:0]          ts_w;
  logic [TIME_WIDTH-1:0]          gap;
  logic [TIME_WIDTH-1:0]          period_full;
  logic [CMP_W-1:0]               gap_x;
  logic [CMP_W-1:0]               min_gap_x;
  logic                           edge_ok;
  logic [ACC_W-1:0]               preload;
  logic [ACC_W-1:0]               acc_filt;

  // Timestamp brought to the time counter width.
  generate
    if (TIME_WIDTH <= trpm_pkg::TS_W) begin : g_ts_trunc
      assign ts_w = item.timestamp_us[TIME_WIDTH-1:0];
    end else begin : g_ts_ext
      assign ts_w = {{(TIME_WIDTH - trpm_pkg::TS_W){1'b0}}, item.timestamp_us};
    end
  endgenerate

  // Edge qualification: gap strictly above the minimum and the pin back low.
  assign gap         = ts_w - prev_edge_r;
  assign period_full = ts_w - prev_valid_r;
  assign gap_x       = CMP_W'(gap);
  assign min_gap_x   = CMP_W'(cfg.min_gap_us);
  assign edge_ok     = (gap_x > min_gap_x) && !item.pin_level;

  // Settled filter value for a stream of maximum periods.
  assign preload  = ACC_W'({cfg.max_period_us, {FILTER_SHIFT{1'b0}}});
  // One step of the exponential filter.
  assign acc_filt = acc_r - (acc_r >> FILTER_SHIFT) + ACC_W'(period_r);

  always_comb begin
    acc_nxt        = acc_r;
    period_nxt     = period_r;
    hold_nxt       = hold_r;
    prev_edge_nxt  = prev_edge_r;
    prev_valid_nxt = prev_valid_r;
    if (apply) begin
      if (item.op == trpm_pkg::OP_EDGE) begin
        prev_edge_nxt = ts_w;
        if (edge_ok) begin
          period_nxt     = period_full[PERIOD_W-1:0];
          prev_valid_nxt = ts_w;
          hold_nxt       = cfg.hold_ticks;
          if (hold_r == '0) begin
            acc_nxt = preload;
          end
        end
      end else begin
        if (hold_r != '0) begin
          acc_nxt  = acc_filt;
          hold_nxt = hold_r - 1'b1;
        end else begin
          acc_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      period_r     <= '0;
      hold_r       <= '0;
      prev_edge_r  <= '0;
      prev_valid_r <= '0;
    end else begin
      acc_r        <= acc_nxt;
      period_r     <= period_nxt;
      hold_r       <= hold_nxt;
      prev_edge_r  <= prev_edge_nxt;
      prev_valid_r <= prev_valid_nxt;
    end
  end

  assign acc     = acc_r;
  assign hold_nz = (hold_r != '0);

endmodule

// ===== sv/trpm_div.sv =====
`timescale 1ns / 1ps

module trpm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [trpm_pkg::DIV_W-1:0]    divisor,
  output logic                          done,
  output logic [trpm_pkg::NUM_W-1:0]    quotient
);

  localparam int DIV_W  = trpm_pkg::DIV_W;
  localparam int NUM_W  = trpm_pkg::NUM_W;
  localparam int STEP_W = trpm_pkg::STEP_W;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [DIV_W-1:0]    dvs_r, dvs_nxt;
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [NUM_W-1:0]    quo_r, quo_nxt;

  logic [DIV_W:0]      trial;
  logic [DIV_W:0]      diff;
  logic                fits;

  // Shared subtractor: one restoring step per cycle. The quotient register
  // starts out holding the numerator and shifts quotient bits in from below.
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = !diff[DIV_W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(trpm_pkg::DIV_STEPS - 1);
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = trpm_pkg::RPM_NUMERATOR;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_nxt  = {quo_r[NUM_W-2:0], fits};
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/tachometer_rpm_filter_core.sv =====
`timescale 1ns / 1ps

// Filtered tachometer: turns pulse edges and 100 ms ticks into an RPM figure.
// Input channel: one beat per event. in_op selects a pulse edge (with its
// microsecond timestamp and sampled pin level) or a filter tick. A beat is
// taken when in_valid is high and in_stall is low.
// Output channel: every input beat yields exactly one output beat carrying
// out_rpm (0 when no valid measurement) and out_measuring.
// Configuration: cfg_index/cfg_data write min gap, max period and hold
// ticks; cfg_ready is always high. Write only while the block is idle.
// Sequencing: a division runs in the bit-serial divider, one quotient bit
// per cycle, and is skipped when the result is zero. The next input beat
// can be taken in the cycle after the previous result is loaded, so one
// item is worked on at a time. in_stall is high while an item is in
// progress.
// Receiver stall: the output register holds its beat; the next item may be
// taken and worked on meanwhile, and waits at its end until the register
// frees up.
// Reset: all filter state clears, the registers take their defaults, and
// no output beat is pending.
module tachometer_rpm_filter_core #(
  parameter int FILTER_SHIFT = 2,
  parameter int TIME_WIDTH   = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic [trpm_pkg::TS_W-1:0]        in_timestamp_us,
  input  logic                             in_pin_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [trpm_pkg::RPM_W-1:0]       out_rpm,
  output logic                             out_measuring,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [trpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trpm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int ACC_W = trpm_pkg::ACC_W;
  localparam int AVG_W = ACC_W - FILTER_SHIFT;

  trpm_pkg::trpm_state_t           state_r, state_nxt;
  trpm_pkg::trpm_item_t            item_r, item_nxt;
  trpm_pkg::trpm_cfg_t             cfg;

  logic                            rpm_ok_r, rpm_ok_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [trpm_pkg::RPM_W-1:0]      out_rpm_r, out_rpm_nxt;
  logic                            out_meas_r, out_meas_nxt;

  logic                            in_take;
  logic                            apply;
  logic                            div_start;
  logic                            div_done;
  logic [trpm_pkg::NUM_W-1:0]      div_q;
  logic [ACC_W-1:0]                acc;
  logic                            hold_nz;
  logic [AVG_W-1:0]                avg;
  logic                            avg_bad;
  logic                            out_load;

  trpm_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  trpm_state #(
    .FILTER_SHIFT (FILTER_SHIFT),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .apply   (apply),
    .item    (item_r),
    .cfg     (cfg),
    .acc     (acc),
    .hold_nz (hold_nz)
  );

  trpm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (avg[trpm_pkg::DIV_W-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  // Average period and its validity window.
  assign avg     = acc[ACC_W-1:FILTER_SHIFT];
  assign avg_bad = (avg == '0) || (avg > AVG_W'(cfg.max_period_us));

  assign in_stall = (state_r != trpm_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign apply    = (state_r == trpm_pkg::ST_UPDATE);

  // Sequencer: capture, update state, check range, divide when in range, deliver.
  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    rpm_ok_nxt = rpm_ok_r;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      trpm_pkg::ST_IDLE: begin
        if (in_take) begin
          item_nxt.op           = in_op;
          item_nxt.timestamp_us = in_timestamp_us;
          item_nxt.pin_level    = in_pin_level;
          state_nxt             = trpm_pkg::ST_UPDATE;
        end
      end
      trpm_pkg::ST_UPDATE: begin
        state_nxt = trpm_pkg::ST_CHECK;
      end
      trpm_pkg::ST_CHECK: begin
        rpm_ok_nxt = !avg_bad;
        if (avg_bad) begin
          state_nxt = trpm_pkg::ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = trpm_pkg::ST_DIVIDE;
        end
      end
      trpm_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = trpm_pkg::ST_DONE;
        end
      end
      trpm_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = trpm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = trpm_pkg::ST_IDLE;
    endcase
  end

  // Output register: holds a beat until the receiver takes it.
  always_comb begin
    out_rpm_nxt  = out_rpm_r;
    out_meas_nxt = out_meas_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_rpm_nxt   = rpm_ok_r ? div_q : '0;
      out_meas_nxt  = hold_nz;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trpm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    rpm_ok_r   <= rpm_ok_nxt;
    out_rpm_r  <= out_rpm_nxt;
    out_meas_r <= out_meas_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_rpm       = out_rpm_r;
  assign out_measuring = out_meas_r;

  // A new output beat only appears at the end of an item.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == trpm_pkg::ST_DONE))
    else $error("output beat raised outside the delivery step");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == trpm_pkg::ST_DIVIDE))
    else $error("divider finished while the sequencer was not waiting");

  // The quotient can never exceed the numerator.
  a_rpm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rpm_r <= trpm_pkg::RPM_NUMERATOR))
    else $error("rpm result out of range");

  // A division is only started on an in-range average.
  a_div_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !avg_bad)
    else $error("division started on an invalid average");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int MAX_REPORTS     = 10;
  localparam int FILTER_SHIFT    = 2;

  // Local copies of the package widths.
  localparam int TS_W       = trpm_pkg::TS_W;
  localparam int RPM_W      = trpm_pkg::RPM_W;
  localparam int MIN_GAP_W  = trpm_pkg::MIN_GAP_W;
  localparam int MAX_PER_W  = trpm_pkg::MAX_PER_W;
  localparam int HOLD_W     = trpm_pkg::HOLD_W;
  localparam int ACC_W      = trpm_pkg::ACC_W;
  localparam int CFG_IDX_W  = trpm_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = trpm_pkg::CFG_DATA_W;

  // One result beat as the block reports it.
  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic             measuring;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_op = trpm_pkg::OP_EDGE;
  logic [TS_W-1:0]       in_timestamp_us = '0;
  logic                  in_pin_level = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [RPM_W-1:0]      out_rpm;
  logic                  out_measuring;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = trpm_pkg::REG_MIN_GAP;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the tachometer registers and filter state.
  logic [MIN_GAP_W-1:0] gap_limit_us;
  logic [MAX_PER_W-1:0] period_limit_us;
  logic [HOLD_W-1:0]    hold_reload;
  logic [ACC_W-1:0]     period_acc;
  logic [TS_W-1:0]      period_us;
  logic [HOLD_W-1:0]    hold_left;
  logic [TS_W-1:0]      last_edge_us;
  logic [TS_W-1:0]      last_valid_edge_us;

  trpm_pkg::trpm_item_t pulse_items[$];
  reading_t             pending_readings[$];

  int unsigned items_queued = 0;
  int unsigned readings_seen = 0;
  int unsigned cfg_writes_done = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_burst_left = 0;
  int unsigned tx_gap_left = 0;
  int unsigned stim_gap_us = 2000;
  bit          idling_on = 1'b1;
  logic        in_beat_taken = 1'b0;
  logic [TS_W-1:0] stim_now = '0;

  tachometer_rpm_filter_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_timestamp_us (in_timestamp_us),
    .in_pin_level    (in_pin_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rpm         (out_rpm),
    .out_measuring   (out_measuring),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Apply one item to the mirrored state and return the reading it yields.
  function automatic reading_t tacho_apply(trpm_pkg::trpm_item_t it);
    logic [TS_W-1:0] gap;
    logic [TS_W-1:0] avg;
    reading_t        r;
    if (it.op == trpm_pkg::OP_EDGE) begin
      // Debounce: the gap counts from the previous edge, accepted or not.
      gap = it.timestamp_us - last_edge_us;
      if (gap > TS_W'(gap_limit_us) && it.pin_level == 1'b0) begin
        period_us = it.timestamp_us - last_valid_edge_us;
        last_valid_edge_us = it.timestamp_us;
        if (hold_left == '0) begin
          period_acc = ACC_W'(period_limit_us) << FILTER_SHIFT;
        end
        hold_left = hold_reload;
      end
      last_edge_us = it.timestamp_us;
    end else begin
      period_acc = period_acc - (period_acc >> FILTER_SHIFT) + ACC_W'(period_us);
      if (hold_left != '0) begin
        hold_left = hold_left - 1'b1;
      end else begin
        period_acc = '0;
      end
    end
    avg = TS_W'(period_acc >> FILTER_SHIFT);
    if (avg == '0 || avg > TS_W'(period_limit_us)) begin
      r.rpm = '0;
    end else begin
      r.rpm = RPM_W'(TS_W'(trpm_pkg::RPM_NUMERATOR) / avg);
    end
    r.measuring = (hold_left != '0);
    return r;
  endfunction

  // Monitor: register writes, input and result beats, and the watchdog.
  always @(posedge clk) begin
    reading_t seen;
    reading_t want;
    bit       any_beat;
    if (!rst_n) begin
      gap_limit_us       = trpm_pkg::MIN_GAP_RST;
      period_limit_us    = trpm_pkg::MAX_PER_RST;
      hold_reload        = trpm_pkg::HOLD_RST;
      period_acc         = '0;
      period_us          = '0;
      hold_left          = '0;
      last_edge_us       = '0;
      last_valid_edge_us = '0;
      in_beat_taken     <= 1'b0;
    end else begin
      any_beat = 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          trpm_pkg::REG_MIN_GAP:    gap_limit_us = cfg_data[MIN_GAP_W-1:0];
          trpm_pkg::REG_MAX_PERIOD: period_limit_us = cfg_data[MAX_PER_W-1:0];
          trpm_pkg::REG_HOLD_TICKS: hold_reload = cfg_data[HOLD_W-1:0];
          default: ;
        endcase
        cfg_writes_done++;
        any_beat = 1'b1;
      end
      // A result beat is checked against the oldest prediction.
      if (out_valid && !out_stall) begin
        seen = {out_rpm, out_measuring};
        readings_seen++;
        any_beat = 1'b1;
        if (pending_readings.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: result beat with nothing expected: rpm=%0d measuring=%0b",
                     $realtime, seen.rpm, seen.measuring);
          end
        end else begin
          want = pending_readings.pop_front();
          if (seen.rpm !== want.rpm || seen.measuring !== want.measuring) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: mismatch: expected rpm=%0d measuring=%0b, got rpm=%0d measuring=%0b",
                       $realtime, want.rpm, want.measuring, seen.rpm, seen.measuring);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_readings.push_back(tacho_apply({in_op, in_timestamp_us, in_pin_level}));
        any_beat = 1'b1;
      end
      in_beat_taken <= in_valid && !in_stall;
      if (any_beat) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no beat for %0d cycles", $realtime, WATCHDOG_LIMIT);
          $display("** tachometer_rpm_filter_core: FAILED **");
          $finish;
        end
      end
    end
  end

  // Driver: presents queued items, with random gaps between beats while idling_on is set.
  always @(negedge clk) begin
    trpm_pkg::trpm_item_t next_item;
    logic                 next_valid;
    next_item  = {in_op, in_timestamp_us, in_pin_level};
    next_valid = in_valid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && in_beat_taken) begin
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
        end else if (pulse_items.size() != 0) begin
          if (idling_on && $urandom_range(0, 4) == 0) begin
            tx_gap_left = $urandom_range(1, 17) - 1;
          end else begin
            next_item  = pulse_items.pop_front();
            next_valid = 1'b1;
          end
        end
      end
    end
    in_valid        <= next_valid;
    in_op           <= next_item.op;
    in_timestamp_us <= next_item.timestamp_us;
    in_pin_level    <= next_item.pin_level;
  end

  // Receiver: random stall bursts while idling_on is set, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      rx_hold_left = HOLD_OFF_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else if (rx_burst_left > 0) begin
      rx_burst_left--;
      out_stall <= 1'b1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      rx_burst_left = $urandom_range(1, 17) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_item(logic op, logic [TS_W-1:0] ts, logic level);
    pulse_items.push_back({op, ts, level});
    items_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    int unsigned done_before;
    done_before = cfg_writes_done;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    wait (cfg_writes_done != done_before);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(int unsigned gap, int unsigned max_period, int unsigned hold);
    write_reg(trpm_pkg::REG_MIN_GAP, CFG_DATA_W'(gap));
    write_reg(trpm_pkg::REG_MAX_PERIOD, CFG_DATA_W'(max_period));
    write_reg(trpm_pkg::REG_HOLD_TICKS, CFG_DATA_W'(hold));
    stim_gap_us = gap;
  endtask

  // Wait until every queued item has produced its reading, then let the block settle.
  task automatic wait_idle();
    wait (readings_seen >= items_queued);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Ticks and edges; edges are mostly steady rotation with random periods, the rest bounce, wraps and jumps.
  task automatic queue_traffic(int count, int unsigned period_lo, int unsigned period_hi);
    int unsigned pick;
    int unsigned burst;
    logic [TS_W-1:0] delta;
    logic level;
    int n;
    n = 0;
    while (n < count) begin
      pick  = $urandom_range(0, 99);
      level = 1'b0;
      if (pick < 5) begin
        // A run of ticks can let the hold counter run out.
        burst = $urandom_range(2, 25);
        repeat (burst) queue_item(trpm_pkg::OP_TICK, $urandom(), 1'($urandom_range(0, 1)));
        n += burst;
      end else if (pick < 32) begin
        queue_item(trpm_pkg::OP_TICK, $urandom(), 1'($urandom_range(0, 1)));
        n++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          delta = $urandom_range(period_lo, period_hi);
          level = ($urandom_range(0, 9) == 0);
        end else if (pick < 82) begin
          delta = $urandom_range(0, stim_gap_us);
          level = 1'($urandom_range(0, 1));
        end else if (pick < 87) begin
          delta = stim_gap_us;
        end else if (pick < 92) begin
          delta = stim_gap_us + 1;
        end else if (pick < 96) begin
          delta = $urandom();
          level = 1'($urandom_range(0, 1));
        end else begin
          delta = $urandom() - stim_now;
          level = 1'($urandom_range(0, 1));
        end
        stim_now = stim_now + delta;
        queue_item(trpm_pkg::OP_EDGE, stim_now, level);
        n++;
      end
    end
  endtask

  task automatic run_phase(int unsigned gap, int unsigned max_period, int unsigned hold,
                           int count, int unsigned period_lo, int unsigned period_hi,
                           bit with_idle, bit with_hold_off);
    int unsigned start_seen;
    set_config(gap, max_period, hold);
    idling_on  = with_idle;
    start_seen = readings_seen;
    queue_traffic(count, period_lo, period_hi);
    if (with_hold_off) begin
      // Hold the result side off while the sender keeps offering beats.
      wait (readings_seen >= start_seen + 5);
      hold_requests++;
    end
    wait_idle();
  endtask

  initial begin
    int unsigned rnd_gap;
    int unsigned rnd_max;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed edges under the reset settings: debounce limits, pin level,
    // first edge from time zero, and timestamp wrap.
    queue_item(trpm_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b1);
    queue_item(trpm_pkg::OP_EDGE, 32'd1500, 1'b0);
    queue_item(trpm_pkg::OP_EDGE, 32'd3500, 1'b0);
    queue_item(trpm_pkg::OP_EDGE, 32'd5501, 1'b0);
    queue_item(trpm_pkg::OP_EDGE, 32'd20000, 1'b1);
    queue_item(trpm_pkg::OP_EDGE, 32'd40000, 1'b0);
    repeat (3) queue_item(trpm_pkg::OP_TICK, 32'd0, 1'b0);
    queue_item(trpm_pkg::OP_EDGE, 32'hFFFF_F000, 1'b0);
    queue_item(trpm_pkg::OP_EDGE, 32'h0000_1000, 1'b0);
    queue_item(trpm_pkg::OP_TICK, 32'h5555_5555, 1'b0);
    queue_item(trpm_pkg::OP_EDGE, 32'hFFFF_FFFF, 1'b1);
    queue_item(trpm_pkg::OP_EDGE, 32'h0000_0000, 1'b1);
    wait_idle();

    // Smallest settings: unit period gives the top speed, a single hold
    // tick expires at once and the accumulator clears.
    set_config(0, 1, 1);
    queue_item(trpm_pkg::OP_EDGE, 32'd1, 1'b0);
    queue_item(trpm_pkg::OP_EDGE, 32'd2, 1'b0);
    queue_item(trpm_pkg::OP_TICK, 32'd0, 1'b0);
    queue_item(trpm_pkg::OP_TICK, 32'd0, 1'b0);
    queue_item(trpm_pkg::OP_EDGE, 32'd3, 1'b0);
    queue_item(trpm_pkg::OP_EDGE, 32'd3, 1'b0);
    queue_item(trpm_pkg::OP_TICK, 32'd0, 1'b0);
    queue_item(trpm_pkg::OP_TICK, 32'd0, 1'b0);
    stim_now = 32'd3;
    wait_idle();

    run_phase(2000, 1000000, 20, 110, 2001, 80000, 1'b1, 1'b0);
    run_phase(0, 1, 1, 80, 0, 3, 1'b1, 1'b0);
    run_phase(1000000, 16777215, 255, 100, 1000001, 6000000, 1'b1, 1'b1);
    rnd_gap = $urandom_range(0, 1000000);
    rnd_max = $urandom_range(1, 16777215);
    run_phase(rnd_gap, rnd_max, $urandom_range(1, 255), 100, rnd_gap + 1,
              rnd_gap + 1 + rnd_max, 1'b1, 1'b0);
    run_phase(500, 5000, 3, 140, 400, 7000, 1'b1, 1'b0);
    // Closing stretch at full rate on both sides.
    run_phase(2000, 1000000, 20, 150, 2001, 120000, 1'b0, 1'b0);

    if (fail_count == 0 && pending_readings.size() == 0) begin
      $display("** tachometer_rpm_filter_core: PASSED **");
    end else begin
      $display("** tachometer_rpm_filter_core: FAILED **");
    end
    $finish;
  end

endmodule
